// File: rtl/box_average_3x3_edge_normalized_macros.svh
// Assertion macros for the 3x3 box average block.
// Used by the port checker; depends on nothing else.
`ifndef BOX_AVERAGE_3X3_EDGE_NORMALIZED_MACROS_SVH
`define BOX_AVERAGE_3X3_EDGE_NORMALIZED_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define BAVG_CHK_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bavg check failed");

// antecedent implies consequent in the same cycle
`define BAVG_CHK_NOW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("bavg check failed");

`endif

// File: rtl/bavg_pkg.sv
// Shared types and constants of the 3x3 box average block.
// No dependencies.
`timescale 1ns / 1ps

package bavg_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int CFG_W        = 11;
  localparam int PIX_W        = 8;
  localparam int SUM_W        = 12;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  // register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd2;

  // divisor kinds
  localparam logic [1:0] DIV_BY4 = 2'd0;
  localparam logic [1:0] DIV_BY6 = 2'd1;
  localparam logic [1:0] DIV_BY9 = 2'd2;

  // reciprocals scaled by 2^16, exact for all sums in range
  localparam logic [13:0] RECIP6 = 14'd10923;
  localparam logic [13:0] RECIP9 = 14'd7282;
  localparam int          RECIP_SH = 16;

  // one window: px[col][row], col 0 = left, row 0 = top
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] px;
    logic                       has_top;
    logic                       has_bot;
    logic                       has_lft;
    logic                       has_rgt;
    logic                       last;
  } win_t;

endpackage

// File: rtl/bavg_front.sv
// Front end: config registers, position counters, line buffers, window.
// Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_front #(
  parameter int MAX_COLS = bavg_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = bavg_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bavg_pkg::PIX_W-1:0]   in_pixel,
  input  logic                         in_drain,
  input  logic                         cfg_valid,
  input  logic                         cfg_index,
  input  logic [bavg_pkg::CFG_W-1:0]   cfg_data,
  input  logic [bavg_pkg::QCNT_W-1:0]  q_count,
  output logic                         push_valid,
  output bavg_pkg::win_t               push_data
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int ECW = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 2);
  localparam int SW  = $clog2(MAX_ROWS * MAX_COLS + 1);

  logic [bavg_pkg::CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [RW-1:0]  rows_eff;
  logic [ECW-1:0] cols_eff;
  logic [SW-1:0]  total;

  logic [RW-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [SW-1:0]  seen_r, seen_nxt;
  logic [ECW-1:0] in_col_inc, out_col_inc;

  logic acc, is_pix, is_drn, step, emit, last;
  logic top_ok, bot_ok, lft_ok, rgt_ok;

  logic                       b_step_r, b_pix_r, b_emit_r;
  logic [CW-1:0]              b_col_r;
  logic [bavg_pkg::PIX_W-1:0] b_px_r;
  logic                       b_top_r, b_bot_r, b_lft_r, b_rgt_r, b_last_r;

  logic [bavg_pkg::PIX_W-1:0] lb0_mem [MAX_COLS];
  logic [bavg_pkg::PIX_W-1:0] lb1_mem [MAX_COLS];
  logic [bavg_pkg::PIX_W-1:0] lb0_q, lb1_q;
  logic [2:0][2:0][bavg_pkg::PIX_W-1:0] win_r;
  logic [2:0][bavg_pkg::PIX_W-1:0] new_col;

  // sizes saturated to the supported range
  assign rows_eff = (rows_cfg_r < 11'd2) ? RW'(2) :
                    (32'(rows_cfg_r) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_cfg_r);
  assign cols_eff = (cols_cfg_r < 11'd2) ? ECW'(2) :
                    (32'(cols_cfg_r) > MAX_COLS) ? ECW'(MAX_COLS) : ECW'(cols_cfg_r);
  assign total    = SW'(rows_eff) * SW'(cols_eff);

  // room for this item and the one still in the line buffer stage
  assign in_ready = ({1'b0, q_count} + {3'b000, b_emit_r}) < 4'(bavg_pkg::QDEPTH);
  assign acc      = in_valid & in_ready;

  // classify: real pixel of the image, or drain after image end
  assign is_pix = acc & ~in_drain & (seen_r < total);
  assign is_drn = acc &  in_drain & (seen_r >= total);
  assign step   = is_pix | is_drn;
  assign emit   = is_drn | (is_pix & (seen_r > SW'(cols_eff)));

  assign last   = (out_row_r == rows_eff - 1'b1) && (ECW'(out_col_r) == cols_eff - 1'b1);
  assign top_ok = (out_row_r != '0);
  assign bot_ok = (out_row_r != rows_eff - 1'b1);
  assign lft_ok = (out_col_r != '0);
  assign rgt_ok = (ECW'(out_col_r) != cols_eff - 1'b1);

  assign in_col_inc  = ECW'(in_col_r) + 1'b1;
  assign out_col_inc = ECW'(out_col_r) + 1'b1;

  // position counters
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    seen_nxt    = seen_r;
    if (step) begin
      if (in_col_inc == cols_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = CW'(in_col_inc);
      end
      if (is_pix) begin
        seen_nxt = seen_r + 1'b1;
      end
    end
    if (emit) begin
      if (last) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        seen_nxt    = '0;
      end else if (out_col_inc == cols_eff) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = CW'(out_col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= bavg_pkg::CFG_RESET;
      cols_cfg_r <= bavg_pkg::CFG_RESET;
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      seen_r     <= '0;
      b_step_r   <= 1'b0;
      b_pix_r    <= 1'b0;
      b_emit_r   <= 1'b0;
    end else begin
      b_step_r <= step;
      b_pix_r  <= is_pix;
      b_emit_r <= emit;
      if (cfg_valid) begin
        // a register write restarts the image
        if (cfg_index == bavg_pkg::REG_ROWS) begin
          rows_cfg_r <= cfg_data;
        end else begin
          cols_cfg_r <= cfg_data;
        end
        in_row_r  <= '0;
        in_col_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        seen_r    <= '0;
      end else begin
        in_row_r  <= in_row_nxt;
        in_col_r  <= in_col_nxt;
        out_row_r <= out_row_nxt;
        out_col_r <= out_col_nxt;
        seen_r    <= seen_nxt;
      end
    end
  end

  // payload of the line buffer stage
  always_ff @(posedge clk) begin
    if (step) begin
      b_col_r  <= in_col_r;
      b_px_r   <= in_pixel;
      b_top_r  <= top_ok;
      b_bot_r  <= bot_ok;
      b_lft_r  <= lft_ok;
      b_rgt_r  <= rgt_ok;
      b_last_r <= last;
    end
  end

  // line buffers: read at input column, rows roll down one stage later
  always_ff @(posedge clk) begin
    if (step) begin
      lb0_q <= lb0_mem[in_col_r];
    end
    if (b_pix_r) begin
      lb0_mem[b_col_r] <= lb1_q;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lb1_q <= lb1_mem[in_col_r];
    end
    if (b_pix_r) begin
      lb1_mem[b_col_r] <= b_px_r;
    end
  end

  // 3x3 window shift
  assign new_col = {b_px_r, lb1_q, lb0_q};

  always_ff @(posedge clk) begin
    if (b_step_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= new_col;
    end
  end

  assign push_valid        = b_emit_r;
  assign push_data.px      = {new_col, win_r[2], win_r[1]};
  assign push_data.has_top = b_top_r;
  assign push_data.has_bot = b_bot_r;
  assign push_data.has_lft = b_lft_r;
  assign push_data.has_rgt = b_rgt_r;
  assign push_data.last    = b_last_r;

endmodule

// File: rtl/bavg_fifo.sv
// Short window queue between front and back end.
// Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_valid,
  input  bavg_pkg::win_t              push_data,
  output logic                        pop_valid,
  input  logic                        pop_ready,
  output bavg_pkg::win_t              pop_data,
  output logic [bavg_pkg::QCNT_W-1:0] count
);

  bavg_pkg::win_t                  mem_r [bavg_pkg::QDEPTH];
  logic [bavg_pkg::QPTR_W-1:0]     wptr_r, rptr_r;
  logic [bavg_pkg::QCNT_W-1:0]     cnt_r;
  logic                            pop;

  assign pop       = pop_valid & pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rptr_r];
  assign count     = cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_valid) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + {2'b00, push_valid} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/bavg_back.sv
// Back end: masked window sum, then divide by 4, 6 or 9.
// Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  bavg_pkg::win_t             q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bavg_pkg::PIX_W-1:0] out_mean_pixel,
  output logic                       out_last
);

  logic                             s1_valid_r, s1_last_r, s1_ready, s2_load;
  logic [bavg_pkg::SUM_W-1:0]       sum_r, sum_c;
  logic [1:0]                       kind_r, kind_c;
  logic [2:0]                       rv, cv;
  logic [13:0]                      recip;
  logic [25:0]                      prod;
  logic [bavg_pkg::PIX_W-1:0]       mean_c;
  logic                             out_valid_r;
  logic [bavg_pkg::PIX_W-1:0]       mean_r;
  logic                             last_r;

  assign s2_load  = s1_valid_r & (~out_valid_r | out_ready);
  assign s1_ready = ~s1_valid_r | s2_load;
  assign q_ready  = s1_ready;

  // masked sum of the in-bounds neighbors
  assign rv = {q_data.has_bot, 1'b1, q_data.has_top};
  assign cv = {q_data.has_rgt, 1'b1, q_data.has_lft};

  always_comb begin
    sum_c = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (rv[r] && cv[c]) begin
          sum_c = sum_c + bavg_pkg::SUM_W'(q_data.px[c][r]);
        end
      end
    end
  end

  // neighborhood size: 9 inside, 6 on an edge, 4 at a corner
  always_comb begin
    if ((rv == 3'b111) && (cv == 3'b111)) begin
      kind_c = bavg_pkg::DIV_BY9;
    end else if ((rv == 3'b111) || (cv == 3'b111)) begin
      kind_c = bavg_pkg::DIV_BY6;
    end else begin
      kind_c = bavg_pkg::DIV_BY4;
    end
  end

  // divide by reciprocal multiply; by 4 is a shift
  always_comb begin
    case (kind_r)
      bavg_pkg::DIV_BY6: recip = bavg_pkg::RECIP6;
      bavg_pkg::DIV_BY9: recip = bavg_pkg::RECIP9;
      default:           recip = '0;
    endcase
  end

  assign prod   = 26'(sum_r) * 26'(recip);
  assign mean_c = (kind_r == bavg_pkg::DIV_BY4) ? sum_r[9:2] :
                  prod[bavg_pkg::RECIP_SH +: bavg_pkg::PIX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= q_valid;
      end
      if (~out_valid_r | out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && s1_ready) begin
      sum_r     <= sum_c;
      kind_r    <= kind_c;
      s1_last_r <= q_data.last;
    end
    if (s2_load) begin
      mean_r <= mean_c;
      last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_pixel = mean_r;
  assign out_last       = last_r;

endmodule

// File: rtl/box_average_3x3_edge_normalized.sv
// 3x3 box average, edge normalized: one pixel per cycle unless stalled.
// A completed result passes the line buffer stage, queue, sum and divide stages.
// Each line buffer takes one read and one write per cycle (simple dual port).
// Results trail the input by one row plus one pixel; cols + 1 drains flush them.
// Synchronous active-low reset clears counters and queue, sets size to 2 x 2;
// line buffers keep their contents.
`timescale 1ns / 1ps

module box_average_3x3_edge_normalized #(
  parameter int MAX_COLS = bavg_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = bavg_pkg::DEF_MAX_ROWS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bavg_pkg::PIX_W-1:0] in_pixel,
  input  logic                       in_drain,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bavg_pkg::PIX_W-1:0] out_mean_pixel,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [bavg_pkg::CFG_W-1:0] cfg_data
);

  logic                        push_valid, pop_valid, pop_ready;
  bavg_pkg::win_t              push_data, pop_data;
  logic [bavg_pkg::QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  bavg_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .in_drain   (in_drain),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  bavg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .count      (q_count)
  );

  bavg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_ready        (pop_ready),
    .q_data         (pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean_pixel (out_mean_pixel),
    .out_last       (out_last)
  );

endmodule

// File: rtl/bavg_checker.sv
// Port-level checks of the 3x3 box average block, bound to its top level.
// Depends on box_average_3x3_edge_normalized_macros.svh.
`timescale 1ns / 1ps
`include "box_average_3x3_edge_normalized_macros.svh"

module bavg_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_mean_pixel,
  input logic       out_last
);

  // a stalled result stays
  `BAVG_CHK_NEXT(a_out_hold, clk, rst_n && out_valid && !out_ready, out_valid)
  `BAVG_CHK_NEXT(a_out_stable, clk, rst_n && out_valid && !out_ready, $stable(out_mean_pixel) && $stable(out_last))
  // reset empties the pipeline
  `BAVG_CHK_NEXT(a_rst_empty, clk, !rst_n, !out_valid)
  // queue is empty after reset, so input is open
  `BAVG_CHK_NOW(a_rst_ready, clk, $past(!rst_n), in_ready)

endmodule

bind box_average_3x3_edge_normalized bavg_port_checker u_bavg_port_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_mean_pixel (out_mean_pixel),
  .out_last       (out_last)
);

// File: dv/bavg_checker.sv
// Checker for the 3x3 box average block: watches the config, input and result
// transfers, predicts each mean and compares it. Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [bavg_pkg::PIX_W-1:0] in_pixel,
  input  logic                       in_drain,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [bavg_pkg::PIX_W-1:0] out_mean_pixel,
  input  logic                       out_last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [bavg_pkg::CFG_W-1:0] cfg_data,
  output int                         fail_cnt,
  output int                         means_pending
);

  localparam int HIST_N = 2 * bavg_pkg::DEF_MAX_COLS + 2;

  typedef struct {
    logic [bavg_pkg::PIX_W-1:0] mean;
    logic                       last;
  } mean_t;

  mean_t                      mean_q[$];
  logic [bavg_pkg::PIX_W-1:0] line_mem [HIST_N];
  logic [bavg_pkg::CFG_W-1:0] rows_reg, cols_reg;
  int                         out_r, out_c, pix_taken;

  assign means_pending = mean_q.size();

  function automatic int clamp_size(logic [bavg_pkg::CFG_W-1:0] v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // window mean for the next output position; the newest pixel is not in memory yet
  function automatic mean_t window_mean(int nrows, int ncols,
                                        logic [bavg_pkg::PIX_W-1:0] cur, int cur_idx);
    mean_t m;
    int    sum, cnt, rr, cc, idx;
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = out_r + dr;
        cc = out_c + dc;
        if (rr >= 0 && rr < nrows && cc >= 0 && cc < ncols) begin
          idx = rr * ncols + cc;
          sum += (idx == cur_idx) ? int'(cur) : int'(line_mem[idx % HIST_N]);
          cnt++;
        end
      end
    end
    m.mean = bavg_pkg::PIX_W'(sum / cnt);
    m.last = (out_r == nrows - 1) && (out_c == ncols - 1);
    return m;
  endfunction

  function automatic void advance_out(mean_t m, int ncols);
    if (m.last) begin
      out_r = 0;
      out_c = 0;
      pix_taken = 0;
    end else begin
      out_c++;
      if (out_c >= ncols) begin
        out_c = 0;
        out_r++;
      end
    end
  endfunction

  always @(posedge clk) begin
    mean_t got, want, m;
    int    nrows, ncols;
    if (!rst_n) begin
      rows_reg  = bavg_pkg::CFG_RESET;
      cols_reg  = bavg_pkg::CFG_RESET;
      out_r     = 0;
      out_c     = 0;
      pix_taken = 0;
      mean_q.delete();
      fail_cnt  = 0;
    end else begin
      // result transfer
      if (out_valid && out_ready) begin
        got.mean = out_mean_pixel;
        got.last = out_last;
        if (mean_q.size() == 0) begin
          $error("unexpected result: mean_pixel=%0d last=%0d", got.mean, got.last);
          fail_cnt++;
        end else begin
          want = mean_q.pop_front();
          if (got.mean !== want.mean) begin
            $error("mean_pixel: expected %0d, got %0d", want.mean, got.mean);
            fail_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_cnt++;
          end
        end
      end
      // register write restarts the image
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bavg_pkg::REG_ROWS) rows_reg = cfg_data;
        else cols_reg = cfg_data;
        out_r     = 0;
        out_c     = 0;
        pix_taken = 0;
      end
      // input transfer
      if (in_valid && in_ready) begin
        nrows = clamp_size(rows_reg, bavg_pkg::DEF_MAX_ROWS);
        ncols = clamp_size(cols_reg, bavg_pkg::DEF_MAX_COLS);
        if (in_drain) begin
          if (pix_taken >= nrows * ncols) begin
            m = window_mean(nrows, ncols, '0, -1);
            mean_q.push_back(m);
            advance_out(m, ncols);
          end
        end else if (pix_taken < nrows * ncols) begin
          if (pix_taken >= ncols + 1) begin
            m = window_mean(nrows, ncols, in_pixel, pix_taken);
            mean_q.push_back(m);
            advance_out(m, ncols);
          end
          line_mem[pix_taken % HIST_N] = in_pixel;
          pix_taken++;
        end
      end
    end
  end

endmodule

// File: dv/tb.sv
// Top of the 3x3 box average testbench: clock, reset, stimulus and verdict.
// Depends on bavg_pkg, the block and bavg_checker.
`timescale 1ns / 1ps

module tb;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid, in_ready, in_drain;
  logic [bavg_pkg::PIX_W-1:0] in_pixel;
  logic                       out_valid, out_ready, out_last;
  logic [bavg_pkg::PIX_W-1:0] out_mean_pixel;
  logic                       cfg_valid, cfg_ready, cfg_index;
  logic [bavg_pkg::CFG_W-1:0] cfg_data;
  int                         fail_cnt, means_pending;
  int                         items_sent;
  bit                         quiet;
  logic                       in_xfer, cfg_xfer;

  box_average_3x3_edge_normalized u_dut (.*);

  bavg_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // transfer flags seen by the drivers at the following falling edge
  always @(posedge clk) begin
    in_xfer  <= in_valid && in_ready;
    cfg_xfer <= cfg_valid && cfg_ready;
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic push_item(input logic [bavg_pkg::PIX_W-1:0] px, input logic dr);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_drain <= dr;
    do @(negedge clk); while (!in_xfer);
    items_sent++;
  endtask

  // stop sending and let every expected mean come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (means_pending == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [bavg_pkg::CFG_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_xfer);
    cfg_valid <= 1'b0;
  endtask

  function automatic int eff_size(logic [bavg_pkg::CFG_W-1:0] v);
    return (v < 2) ? 2 : (v > 1024) ? 1024 : int'(v);
  endfunction

  // one image; pat: 0 random, 1 all 255, 2 all 0, 3 alternating 0/255
  task automatic run_image(input int nrows, input int ncols, input int pat, input bit noisy);
    logic [bavg_pkg::PIX_W-1:0] px;
    for (int i = 0; i < nrows * ncols; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) push_item(bavg_pkg::PIX_W'($urandom), 1'b1);
      case (pat)
        1: px = 8'hFF;
        2: px = 8'h00;
        3: px = i[0] ? 8'hFF : 8'h00;
        default: px = bavg_pkg::PIX_W'($urandom);
      endcase
      push_item(px, 1'b0);
    end
    for (int i = 0; i <= ncols; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) push_item(bavg_pkg::PIX_W'($urandom), 1'b0);
      push_item(bavg_pkg::PIX_W'($urandom), 1'b1);
    end
  endtask

  logic [bavg_pkg::CFG_W-1:0] rv, cv;

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pixel   = '0;
    in_drain   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = bavg_pkg::REG_ROWS;
    cfg_data   = '0;
    quiet      = 1'b0;
    items_sent = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset size, early drain, saturated pixels
    push_item(8'h00, 1'b1);
    run_image(2, 2, 1, 1'b0);
    write_reg(bavg_pkg::REG_ROWS, 11'd3);
    write_reg(bavg_pkg::REG_COLS, 11'd3);
    run_image(3, 3, 3, 1'b0);
    // a new image started, then early drains
    push_item(8'hAA, 1'b0);
    for (int i = 0; i < 4; i++) push_item(8'h55, 1'b1);
    // sizes below range saturate to 2
    write_reg(bavg_pkg::REG_ROWS, 11'd0);
    write_reg(bavg_pkg::REG_COLS, 11'd1);
    run_image(2, 2, 2, 1'b0);
    // partial image abandoned by a register write
    write_reg(bavg_pkg::REG_COLS, 11'd3);
    for (int i = 0; i < 5; i++) push_item(bavg_pkg::PIX_W'($urandom), 1'b0);

    // wider image, longer line buffers
    write_reg(bavg_pkg::REG_ROWS, 11'd3);
    write_reg(bavg_pkg::REG_COLS, 11'd100);
    run_image(3, 100, 0, 1'b1);

    // random images, mostly small
    rv = 11'd3;
    cv = 11'd100;
    while (items_sent < 1400) begin
      if (items_sent > 1200) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0)
        write_reg(bavg_pkg::REG_ROWS,
                  bavg_pkg::CFG_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 2047)
                                                                : $urandom_range(2, 7)));
      else if ($urandom_range(0, 1) == 0)
        write_reg(bavg_pkg::REG_ROWS, rv);
      rv = u_chk.rows_reg;
      cv = bavg_pkg::CFG_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 1)
                                                         : $urandom_range(2, 9));
      write_reg(bavg_pkg::REG_COLS, cv);
      rv = u_chk.rows_reg;
      if (eff_size(rv) > 40) begin
        write_reg(bavg_pkg::REG_ROWS, bavg_pkg::CFG_W'($urandom_range(2, 7)));
        rv = u_chk.rows_reg;
      end
      if ($urandom_range(0, 9) == 0) begin
        // broken image, abandoned part way
        for (int i = $urandom_range(1, eff_size(rv) * eff_size(cv)); i > 0; i--)
          push_item(bavg_pkg::PIX_W'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        run_image(eff_size(rv), eff_size(cv), 0, !quiet);
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
